/* rtl/bbpt_pkg.sv */
// ============================================================================
// bbpt_pkg
// Shared widths, character constants and classification helpers for the
// basic pre-tokeniser.
// ============================================================================
package bbpt_pkg;

   // Width of the code point fields.
   localparam int CP_BITS    = 21;
   // Code point bits that take part in classification (16 to 21).
   localparam int CHAR_BITS  = 21;
   // Stream data width: code point padded to whole bytes.
   localparam int TDATA_BITS = ((CP_BITS + 7) / 8) * 8;

   localparam logic [CP_BITS-1:0] CHAR_MASK =
      CP_BITS'((64'd1 << CHAR_BITS) - 64'd1);

   typedef logic [CP_BITS-1:0] cp_type;

   localparam cp_type CP_TAB      = 21'h00009;
   localparam cp_type CP_LF       = 21'h0000A;
   localparam cp_type CP_CR       = 21'h0000D;
   localparam cp_type CP_C0_LAST  = 21'h0001F;
   localparam cp_type CP_SPACE    = 21'h00020;
   localparam cp_type CP_DEL      = 21'h0007F;
   localparam cp_type CP_C1_FIRST = 21'h00080;
   localparam cp_type CP_C1_LAST  = 21'h0009F;
   localparam cp_type CP_NBSP     = 21'h000A0;
   localparam cp_type CP_REPLACE  = 21'h0FFFD;
   localparam cp_type CP_IDEO_SP  = 21'h03000;
   localparam cp_type CP_MUL_SIGN = 21'h000D7;
   localparam cp_type CP_CASE_BIT = 21'h00020;

   // Result of classifying one item.
   typedef struct packed {
      logic   emit;       // a result item is produced
      logic   starts;     // result begins a new token
      logic   done;       // end-of-text marker
      cp_type chr;        // character of the result
      logic   word_next;  // inside-word flag after this item
   } class_type;

   function automatic logic in_range(input cp_type c, input cp_type lo, input cp_type hi);
      in_range = (c >= lo) && (c <= hi);
   endfunction

   function automatic logic is_control(input cp_type c);
      logic keep;
      keep = (c == CP_TAB) || (c == CP_LF) || (c == CP_CR);
      is_control = !keep && ((c <= CP_C0_LAST) || (c == CP_DEL) || (c == CP_REPLACE) ||
                             in_range(c, CP_C1_FIRST, CP_C1_LAST));
   endfunction

   function automatic logic is_space(input cp_type c);
      is_space = (c == CP_SPACE) || (c == CP_TAB) || (c == CP_LF) || (c == CP_CR) ||
                 (c == CP_NBSP) || (c == 21'h01680) || in_range(c, 21'h02000, 21'h0200A) ||
                 (c == 21'h0202F) || (c == 21'h0205F) || (c == CP_IDEO_SP);
   endfunction

   function automatic logic is_cjk(input cp_type c);
      is_cjk = in_range(c, 21'h04E00, 21'h09FFF) || in_range(c, 21'h03400, 21'h04DBF) ||
               in_range(c, 21'h20000, 21'h2A6DF) || in_range(c, 21'h2A700, 21'h2CEAF) ||
               in_range(c, 21'h0F900, 21'h0FAFF) || in_range(c, 21'h2F800, 21'h2FA1F);
   endfunction

   function automatic logic is_punct(input cp_type c);
      is_punct = in_range(c, 21'h00021, 21'h0002F) || in_range(c, 21'h0003A, 21'h00040) ||
                 in_range(c, 21'h0005B, 21'h00060) || in_range(c, 21'h0007B, 21'h0007E) ||
                 in_range(c, 21'h000A1, 21'h000BF) || in_range(c, 21'h02010, 21'h02060) ||
                 in_range(c, 21'h02100, 21'h0214F) || in_range(c, 21'h02190, 21'h022FF) ||
                 in_range(c, 21'h03000, 21'h0303F) || in_range(c, 21'h0FE50, 21'h0FE6F) ||
                 in_range(c, 21'h0FF01, 21'h0FF0F) || in_range(c, 21'h0FF1A, 21'h0FF20) ||
                 in_range(c, 21'h0FF3B, 21'h0FF40) || in_range(c, 21'h0FF5B, 21'h0FF65);
   endfunction

   function automatic logic is_mark(input cp_type c);
      is_mark = in_range(c, 21'h00300, 21'h0036F) || in_range(c, 21'h01AB0, 21'h01AFF) ||
                in_range(c, 21'h01DC0, 21'h01DFF);
   endfunction

   // ASCII and Latin-1 upper case only; the lower-case partner sets bit 5.
   function automatic cp_type to_lower(input cp_type c);
      logic upper;
      upper = in_range(c, 21'h00041, 21'h0005A) ||
              (in_range(c, 21'h000C0, 21'h000DE) && (c != CP_MUL_SIGN));
      to_lower = upper ? (c | CP_CASE_BIT) : c;
   endfunction

endpackage

/* rtl/bbpt_classify.sv */
// ============================================================================
// bbpt_classify
// Combinational classification of one registered item: decides whether a
// character is emitted, its lower-case form and the next word flag.
// ============================================================================
module bbpt_classify
   import bbpt_pkg::*;
(
   input  cp_type    code_point,
   input  logic      text_end,
   input  logic      inside_word,
   output class_type result
);

   cp_type c;
   cp_type lc;

   assign c  = code_point & CHAR_MASK;
   assign lc = to_lower(c);

   always_comb begin
      result.emit      = 1'b0;
      result.starts    = 1'b0;
      result.done      = 1'b0;
      result.chr       = '0;
      result.word_next = inside_word;
      priority if (text_end) begin
         result.emit      = 1'b1;
         result.done      = 1'b1;
         result.word_next = 1'b0;
      end else if (is_control(c)) begin
         // dropped, word flag kept
      end else if (is_space(c)) begin
         result.word_next = 1'b0;
      end else if (is_cjk(c) || is_punct(c)) begin
         result.emit      = 1'b1;
         result.starts    = 1'b1;
         result.chr       = c;
         result.word_next = 1'b0;
      end else if (is_mark(lc)) begin
         // combining mark: dropped, word flag kept
      end else begin
         result.emit      = 1'b1;
         result.starts    = !inside_word;
         result.chr       = lc;
         result.word_next = 1'b1;
      end
   end

endmodule

/* rtl/bert_basic_pretokenizer_core.sv */
// ============================================================================
// bert_basic_pretokenizer_core
// Streaming basic pre-tokeniser: one code point in, at most one token
// character out.
// ============================================================================
// Each req transfer carries one code point (req_tdata) or, with req_tlast
// high, an end-of-text mark. Control characters, NUL, U+FFFD and combining
// marks are dropped; whitespace closes the current word and gives nothing;
// CJK ideographs and punctuation come out as one-character tokens; every
// other character is lower-cased (ASCII and Latin-1) and joined to the open
// word. rsp_tuser flags the first character of each token, and an end-of-
// text mark comes out as a transfer with rsp_tlast high and zero data. The
// block takes one item per clock unless an item that has a result must wait
// for a busy output register: an item is registered on entry, classified in
// the following cycle and written to the output register when that register
// is free, after which its result is offered on rsp. The only feedback is the
// one-bit word flag, which is updated as each item leaves the input register,
// so it adds no stall between items. When rsp_tready is low the output
// register holds; items that produce no result still drain past it.
// ============================================================================
module bert_basic_pretokenizer_core
   import bbpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_BITS-1:0] req_tdata,   // [20:0] code_point, rest zero
   input  logic                  req_tlast,   // text_end
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_BITS-1:0] rsp_tdata,   // [20:0] token_char, rest zero
   output logic                  rsp_tuser,   // starts_token
   output logic                  rsp_tlast    // text_done
);

   // input register
   logic      in_valid_ff, in_valid_in;
   cp_type    in_cp_ff;
   logic      in_end_ff;

   // word state
   logic      word_ff, word_in;

   // output register
   logic      out_valid_ff, out_valid_in;
   cp_type    out_chr_ff;
   logic      out_starts_ff;
   logic      out_done_ff;

   class_type cls;
   logic      out_free;
   logic      retire;
   logic      load_out;
   logic      req_xfer;

   bbpt_classify u_classify (
      .code_point  (in_cp_ff),
      .text_end    (in_end_ff),
      .inside_word (word_ff),
      .result      (cls)
   );

   // An item leaves the input register when it has nothing to emit or the
   // output register can take its result this cycle.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign retire     = in_valid_ff && (!cls.emit || out_free);
   assign load_out   = retire && cls.emit;
   assign req_tready = !in_valid_ff || retire;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !retire);
   assign word_in      = retire ? cls.word_next : word_ff;
   assign out_valid_in = load_out || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         word_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         word_ff      <= word_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cp_ff  <= req_tdata[CP_BITS-1:0];
         in_end_ff <= req_tlast;
      end
      if (load_out) begin
         out_chr_ff    <= cls.chr;
         out_starts_ff <= cls.starts;
         out_done_ff   <= cls.done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(out_chr_ff);
   assign rsp_tuser  = out_starts_ff;
   assign rsp_tlast  = out_done_ff;

endmodule

/* rtl/bbpt_checker.sv */
// ============================================================================
// bbpt_checker
// Port-level assertions for the basic pre-tokeniser, bound to the top level.
// ============================================================================
module bbpt_checker
   import bbpt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [TDATA_BITS-1:0] req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [TDATA_BITS-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // last result transfer was an end-of-text mark (true after reset)
   logic last_done_ff, last_done_in;
   logic req_seen;

   assign req_seen     = req_tvalid && req_tready && (req_tdata != '0) && req_tlast;
   assign last_done_in = (rsp_tvalid && rsp_tready) ? rsp_tlast : last_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_done_ff <= 1'b1;
      end else begin
         last_done_ff <= last_done_in;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // end marker carries no character
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata == '0) && !rsp_tuser)
      else $error("end marker with character data");

   // first character after reset or an end marker opens a token
   a_first_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && last_done_ff |-> rsp_tuser)
      else $error("first character of text does not start a token");

   // no ASCII upper case and no C0 control leaves the block
   a_no_upper: assert property (@(posedge clock) disable iff (reset || req_seen)
      rsp_tvalid && !rsp_tlast |->
      !((rsp_tdata >= TDATA_BITS'(21'h41)) && (rsp_tdata <= TDATA_BITS'(21'h5A))) &&
      (rsp_tdata > TDATA_BITS'(CP_C0_LAST)))
      else $error("upper-case or control character emitted");

   // nothing valid straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind bert_basic_pretokenizer_core bbpt_checker u_bbpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* tb/tb_bert_basic_pretokenizer_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_bert_basic_pretokenizer_core
// Self-checking bench for the basic pre-tokeniser: code points are streamed
// in, each result transfer is checked against a behavioural prediction of
// the token characters, start flags and end-of-text marks.
// ============================================================================
module tb_bert_basic_pretokenizer_core;
   import bbpt_pkg::*;

   // Code point bits that survive the width cut before classification.
   localparam cp_type CHAR_KEEP = cp_type'((64'd1 << CHAR_BITS) - 64'd1);

   // One expected result transfer.
   typedef struct packed {
      cp_type chr;     // token_char
      logic   starts;  // starts_token
      logic   done;    // text_done
   } token_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TDATA_BITS-1:0] req_tdata;   // [20:0] code_point, rest zero
   logic                  req_tlast;   // text_end
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [TDATA_BITS-1:0] rsp_tdata;   // [20:0] token_char, rest zero
   logic                  rsp_tuser;   // starts_token
   logic                  rsp_tlast;   // text_done

   // Predicted token characters, oldest first.
   token_type pending_chars [$];
   // Word flag of the prediction: an ordinary-character word is open.
   bit     word_open = 1'b0;

   int     mismatches     = 0;
   int     send_gap_max   = 10;   // sender idle cycles drawn per item, 0..this
   int     recv_stall_max = 10;   // receiver stall drawn per result, 0..this
   int     stall_left     = 0;
   int     hold_len       = 0;
   bit     rsp_hold       = 1'b0;
   event   hold_go;

   // Class boundaries of the character tables; noise lands on and beside them.
   cp_type class_edges [] = '{
      21'h0001F, 21'h00020, 21'h00021, 21'h0002F, 21'h00030, 21'h00039, 21'h0003A,
      21'h00040, 21'h00041, 21'h0005A, 21'h0005B, 21'h00060, 21'h00061, 21'h0007A,
      21'h0007B, 21'h0007E, 21'h0007F, 21'h00080, 21'h0009F, 21'h000A0, 21'h000A1,
      21'h000BF, 21'h000C0, 21'h000D7, 21'h000DE, 21'h000DF, 21'h00300, 21'h0036F,
      21'h01680, 21'h01AB0, 21'h01AFF, 21'h01DC0, 21'h01DFF, 21'h02000, 21'h0200A,
      21'h02010, 21'h0202F, 21'h0205F, 21'h02060, 21'h02100, 21'h0214F, 21'h02190,
      21'h022FF, 21'h03000, 21'h0303F, 21'h03400, 21'h04DBF, 21'h04E00, 21'h09FFF,
      21'h0F900, 21'h0FAFF, 21'h0FE50, 21'h0FE6F, 21'h0FF01, 21'h0FF0F, 21'h0FF1A,
      21'h0FF20, 21'h0FF3B, 21'h0FF40, 21'h0FF5B, 21'h0FF65, 21'h0FFFD, 21'h20000,
      21'h2A6DF, 21'h2A700, 21'h2CEAF, 21'h2F800, 21'h2FA1F, 21'h10FFFF, 21'h1FFFFF
   };

   bert_basic_pretokenizer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Character classes of the tokeniser
   // ------------------------------------------------------------------------
   function automatic bit in_span(input cp_type c, input cp_type lo, input cp_type hi);
      return (c >= lo) && (c <= hi);
   endfunction

   // NUL, C0 (tab, LF and CR excepted), DEL, C1 and the replacement char
   function automatic bit is_dropped_ctrl(input cp_type c);
      if (c == 21'h09 || c == 21'h0A || c == 21'h0D)
         return 1'b0;
      return c <= 21'h1F || c == 21'h7F || c == 21'hFFFD || in_span(c, 21'h80, 21'h9F);
   endfunction

   function automatic bit is_blank(input cp_type c);
      case (c)
         21'h00020, 21'h00009, 21'h0000A, 21'h0000D, 21'h000A0,
         21'h01680, 21'h0202F, 21'h0205F, 21'h03000: return 1'b1;
         default: return in_span(c, 21'h2000, 21'h200A);
      endcase
   endfunction

   function automatic bit is_ideograph(input cp_type c);
      return in_span(c, 21'h04E00, 21'h09FFF) || in_span(c, 21'h03400, 21'h04DBF) ||
             in_span(c, 21'h20000, 21'h2A6DF) || in_span(c, 21'h2A700, 21'h2CEAF) ||
             in_span(c, 21'h0F900, 21'h0FAFF) || in_span(c, 21'h2F800, 21'h2FA1F);
   endfunction

   function automatic bit is_punct_char(input cp_type c);
      if (c < 21'h100)
         return in_span(c, 21'h21, 21'h2F) || in_span(c, 21'h3A, 21'h40) ||
                in_span(c, 21'h5B, 21'h60) || in_span(c, 21'h7B, 21'h7E) ||
                in_span(c, 21'hA1, 21'hBF);
      return in_span(c, 21'h2010, 21'h2060) || in_span(c, 21'h2100, 21'h214F) ||
             in_span(c, 21'h2190, 21'h22FF) || in_span(c, 21'h3000, 21'h303F) ||
             in_span(c, 21'hFE50, 21'hFE6F) || in_span(c, 21'hFF01, 21'hFF0F) ||
             in_span(c, 21'hFF1A, 21'hFF20) || in_span(c, 21'hFF3B, 21'hFF40) ||
             in_span(c, 21'hFF5B, 21'hFF65);
   endfunction

   function automatic bit is_comb_mark(input cp_type c);
      return in_span(c, 21'h0300, 21'h036F) || in_span(c, 21'h1AB0, 21'h1AFF) ||
             in_span(c, 21'h1DC0, 21'h1DFF);
   endfunction

   // ASCII and Latin-1 capitals only; the multiplication sign has no partner
   function automatic cp_type fold_case(input cp_type c);
      if (in_span(c, 21'h41, 21'h5A) || (in_span(c, 21'hC0, 21'hDE) && c != 21'hD7))
         return c + 21'h20;
      return c;
   endfunction

   // Works out the result of one accepted item, if any, and moves the word
   // flag on. Returns 1 when a result transfer is due.
   function automatic bit next_token_char(input cp_type raw, input bit text_end,
                                          output token_type tok);
      cp_type c;
      bit     emits;
      c     = raw & CHAR_KEEP;
      tok   = '0;
      emits = 1'b0;
      if (text_end) begin
         word_open = 1'b0;
         tok.done  = 1'b1;
         emits     = 1'b1;
      end else if (!is_dropped_ctrl(c)) begin
         if (is_blank(c)) begin
            word_open = 1'b0;
         end else if (is_ideograph(c) || is_punct_char(c)) begin
            word_open  = 1'b0;
            tok.chr    = c;
            tok.starts = 1'b1;
            emits      = 1'b1;
         end else begin
            c = fold_case(c);
            // marks vanish without touching the word flag
            if (!is_comb_mark(c)) begin
               tok.chr    = c;
               tok.starts = !word_open;
               word_open  = 1'b1;
               emits      = 1'b1;
            end
         end
      end
      return emits;
   endfunction

   // ------------------------------------------------------------------------
   // Sender: one request transfer per call. Entered and left at a falling
   // edge; valid stays high across back-to-back items, so it is never
   // lowered and raised in one time step.
   // ------------------------------------------------------------------------
   task automatic send_item(input cp_type cp, input bit text_end);
      int        gap;
      token_type tok;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_BITS'(cp);
      req_tlast  <= text_end;
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      // transfer taken at this edge: predict its result in arrival order
      if (next_token_char(cp, text_end, tok))
         pending_chars.push_back(tok);
      @(negedge clock);
   endtask

   // Text-like character mix: mostly letters, with word breaks, punctuation,
   // ideographs, marks and controls sprinkled in.
   function automatic cp_type draw_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 38)
         return 21'h61 + cp_type'($urandom_range(0, 25));
      if (pick < 48)
         return 21'h41 + cp_type'($urandom_range(0, 25));
      if (pick < 53)
         return 21'hC0 + cp_type'($urandom_range(0, 63));
      if (pick < 63) begin
         case ($urandom_range(0, 7))
            0: return 21'h20;
            1: return 21'h09;
            2: return 21'h0A;
            3: return 21'h0D;
            4: return 21'hA0;
            5: return 21'h1680;
            6: return 21'h2000 + cp_type'($urandom_range(0, 10));
            default: begin
               case ($urandom_range(0, 2))
                  0: return 21'h202F;
                  1: return 21'h205F;
                  default: return 21'h3000;
               endcase
            end
         endcase
      end
      if (pick < 71)
         return 21'h21 + cp_type'($urandom_range(0, 93));
      if (pick < 76) begin
         if ($urandom_range(0, 1) == 0)
            return 21'h4E00 + cp_type'($urandom_range(0, 21'h51FF));
         return 21'h20000 + cp_type'($urandom_range(0, 21'hFFFF));
      end
      if (pick < 80) begin
         case ($urandom_range(0, 2))
            0: return 21'h0300 + cp_type'($urandom_range(0, 21'h6F));
            1: return 21'h1AB0 + cp_type'($urandom_range(0, 21'h4F));
            default: return 21'h1DC0 + cp_type'($urandom_range(0, 21'h3F));
         endcase
      end
      if (pick < 84) begin
         case ($urandom_range(0, 3))
            0: return cp_type'($urandom_range(0, 21'h1F));
            1: return 21'h7F;
            2: return 21'h80 + cp_type'($urandom_range(0, 21'h1F));
            default: return 21'hFFFD;
         endcase
      end
      if (pick < 90)
         return 21'h2010 + cp_type'($urandom_range(0, 21'h2FF));
      if (pick < 94)
         return 21'hFE50 + cp_type'($urandom_range(0, 21'h115));
      return cp_type'($urandom);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // End mark straight after reset, with junk on the code point bits.
   task automatic test_text_end;
      send_item(21'h1FFFFF, 1'b1);
   endtask

   // Capitals fold to lower case inside one word; the multiplication sign
   // is left alone.
   task automatic test_case_folding;
      send_item(21'h41, 1'b0);    // 'A' opens a word
      send_item(21'h5A, 1'b0);    // 'Z'
      send_item(21'hC0, 1'b0);    // first Latin-1 capital
      send_item(21'hDE, 1'b0);    // last Latin-1 capital
      send_item(21'hD7, 1'b0);    // multiplication sign
   endtask

   // Controls and marks give nothing and do not break the word.
   task automatic test_dropped_chars;
      send_item(21'h00, 1'b0);    // NUL
      send_item(21'h7F, 1'b0);    // DEL
      send_item(21'h80, 1'b0);    // C1
      send_item(21'hFFFD, 1'b0);  // replacement char
      send_item(21'h0301, 1'b0);  // combining acute
      send_item(21'h62, 1'b0);    // 'b' still continues the word
   endtask

   // Whitespace closes words; punctuation and ideographs stand alone.
   task automatic test_separators;
      send_item(21'h20, 1'b0);    // space
      send_item(21'h78, 1'b0);    // 'x' starts a word
      send_item(21'h3000, 1'b0);  // ideographic space: blank, not punctuation
      send_item(21'h79, 1'b0);    // 'y' starts a word
      send_item(21'h2010, 1'b0);  // hyphen
      send_item(21'h4E00, 1'b0);  // first CJK ideograph
      send_item(21'h2060, 1'b0);  // top of the general punctuation span
   endtask

   // Code points at and past the top of the Unicode range pass as ordinary
   // characters; an end mark inside a word closes it.
   task automatic test_beyond_unicode;
      send_item(21'h10FFFF, 1'b0);
      send_item(21'h1FFFFF, 1'b0);
      send_item(21'h0, 1'b1);
      send_item(21'h61, 1'b0);
   endtask

   // Text-like characters in chunks, each chunk with its own idling on both sides.
   task automatic test_random_text;
      int chunk;
      int n;
      for (chunk = 0; chunk < 14; chunk++) begin
         send_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 10;
         recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
         for (n = 0; n < 100; n++) begin
            if ($urandom_range(0, 39) == 0)
               send_item(cp_type'($urandom), 1'b1);
            else
               send_item(draw_char(), 1'b0);
         end
      end
   endtask

   // Raw code points: whole 21-bit range, class boundaries and their
   // neighbours, and end marks at random.
   task automatic test_random_noise;
      int     n;
      cp_type cp;
      send_gap_max   = 10;
      recv_stall_max = 10;
      for (n = 0; n < 300; n++) begin
         if ($urandom_range(0, 1) == 0)
            cp = cp_type'($urandom);
         else
            cp = class_edges[$urandom_range(0, class_edges.size() - 1)] +
                 cp_type'($urandom_range(0, 2)) - 21'd1;
         send_item(cp, $urandom_range(0, 9) == 0);
      end
   endtask

   // Receiver holds off for a long stretch while ASCII letters and punctuation
   // keep coming, so the output register fills and the request side stalls.
   task automatic test_back_pressure;
      int n;
      send_gap_max = 0;
      hold_len     = 200;
      -> hold_go;
      for (n = 0; n < 40; n++)
         send_item(21'h41 + cp_type'($urandom_range(0, 57)), 1'b0);
      send_gap_max = 10;
   endtask

   // Stop sending and let every predicted result arrive.
   task automatic drain_results;
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_chars.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      // keep watching for anything stray after the last result
      repeat (10) @(posedge clock);
      if (pending_chars.size() != 0)
         $display("%0d expected results never arrived", pending_chars.size());
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------
   // Long hold-off, counted here in cycles; toggled at rising edges so the
   // receiver reads a settled value at the falling edge.
   initial begin : hold_off
      forever begin
         @(hold_go);
         @(posedge clock);
         rsp_hold = 1'b1;
         repeat (hold_len) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   // Ready is driven at the falling edge: low through a hold-off or through
   // the stall drawn after each transfer.
   initial begin : sink
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold || stall_left > 0) begin
            rsp_tready <= 1'b0;
            if (!rsp_hold)
               stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every result transfer is matched against the oldest prediction.
   initial begin : result_check
      token_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (pending_chars.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: char %h start %b done %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata !== TDATA_BITS'(want.chr) || rsp_tuser !== want.starts ||
                   rsp_tlast !== want.done) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected char %h start %b done %b, got %h %b %b",
                              want.chr, want.starts, want.done,
                              rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
            stall_left = $urandom_range(0, recv_stall_max);
         end
      end
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_text_end;
      test_case_folding;
      test_dropped_chars;
      test_separators;
      test_beyond_unicode;
      test_back_pressure;
      test_random_text;
      test_random_noise;
      drain_results;

      if (mismatches == 0 && pending_chars.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
